/* design/mhpq_pkg.sv */
// Package for the binary min-heap priority queue: sizes, key limits,
// command, status and sequencer codes, and the controller/datapath bundle.
// No dependencies; every other design file depends on it.
`default_nettype none

package mhpq_pkg;

  // Heap storage size and the widths that follow from it.
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // Width used for index comparisons, wide enough for any child index.
  localparam int unsigned CMP_W = 32;

  // Fixed payload widths.
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned EIDX_W = 10;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned ECNT_W = 11;

  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_EXTRACT  = 2'd1,
    CMD_DECREASE = 2'd2,
    CMD_DELETE   = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SU_REQ,
    ST_SU_CMP,
    ST_EX_ROOT,
    ST_EX_LAST,
    ST_EX_TAKE,
    ST_SD_LEFT,
    ST_SD_RIGHT,
    ST_SD_CMP,
    ST_FINISH
  } ctrl_state_e;

  // One datapath operation per cycle, chosen by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_REFUSE,
    OP_INS_START,
    OP_DEC_START,
    OP_DEL_START,
    OP_SU_READ,
    OP_SU_MOVE,
    OP_PLACE,
    OP_RD_ROOT,
    OP_RD_LAST,
    OP_EX_TAKE,
    OP_SD_READ_L,
    OP_SD_READ_R,
    OP_SD_MOVE,
    OP_PUBLISH
  } dp_op_e;

  // Status flags returned from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic empty;
    logic idx_bad;
    logic at_root;
    logic parent_gt;
    logic lc_ok;
    logic child_less;
    logic cnt_one;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* design/mhpq_if.sv */
// Handshake interfaces for the command and result channels of the heap.
// Depends on mhpq_pkg for the payload widths.
`default_nettype none

interface mhpq_in_if;
  logic                              valid;
  logic                              ready;
  logic [mhpq_pkg::CMD_W-1:0]        cmd;
  logic signed [mhpq_pkg::KEY_W-1:0] key_value;
  logic [mhpq_pkg::EIDX_W-1:0]       entry_index;

  modport source (output valid, output cmd, output key_value, output entry_index,
                  input ready);
  modport sink   (input valid, input cmd, input key_value, input entry_index,
                  output ready);
endinterface

interface mhpq_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mhpq_pkg::KEY_W-1:0] result_value;
  logic [mhpq_pkg::STAT_W-1:0]       status;
  logic [mhpq_pkg::ECNT_W-1:0]       entry_count;

  modport source (output valid, output result_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input result_value, input status, input entry_count,
                  output ready);
endinterface

`default_nettype wire

/* design/mhpq_datapath.sv */
// Datapath of the heap: key memory, sift registers, key count and the
// result register. Depends on mhpq_pkg; driven by mhpq_ctrl.
`default_nettype none

module mhpq_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mhpq_pkg::dp_op_e                  op_i,
  output mhpq_pkg::dp_status_t              flags_o,
  input  logic [mhpq_pkg::CMD_W-1:0]        cmd_i,
  input  logic signed [mhpq_pkg::KEY_W-1:0] key_value_i,
  input  logic [mhpq_pkg::EIDX_W-1:0]       entry_index_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [mhpq_pkg::KEY_W-1:0] result_value_o,
  output logic [mhpq_pkg::STAT_W-1:0]       status_o,
  output logic [mhpq_pkg::ECNT_W-1:0]       entry_count_o
);
  import mhpq_pkg::*;

  logic signed [KEY_W-1:0] mem_q [DEPTH];
  logic signed [KEY_W-1:0] rdata_q;

  cmd_e                    cmd_q;
  logic signed [KEY_W-1:0] key_q;
  logic [EIDX_W-1:0]       idx_q;
  logic [IDX_W-1:0]        pos_q;
  logic signed [KEY_W-1:0] v_q;
  logic signed [KEY_W-1:0] lval_q;
  logic signed [KEY_W-1:0] root_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [KEY_W-1:0] res_value_q;
  status_e                 res_status_q;
  logic                    out_valid_q;
  logic signed [KEY_W-1:0] out_value_q;
  status_e                 out_status_q;
  logic [CNT_W-1:0]        out_cnt_q;

  logic                    rd_en;
  logic [IDX_W-1:0]        raddr;
  logic                    we;
  logic [IDX_W-1:0]        waddr;
  logic signed [KEY_W-1:0] wdata;

  logic [IDX_W-1:0]        parent;
  logic [CMP_W-1:0]        lc_c;
  logic [CMP_W-1:0]        rc_c;
  logic                    rc_ok;
  logic                    sel_l;
  logic                    sel_r;
  logic signed [KEY_W-1:0] best_l_val;
  logic signed [KEY_W-1:0] best_val;
  logic [IDX_W-1:0]        best_pos;
  logic                    out_free;

  // Heap addressing and child selection.
  assign parent     = IDX_W'((pos_q - IDX_W'(1)) >> 1);
  assign lc_c       = (CMP_W'(pos_q) << 1) + CMP_W'(1);
  assign rc_c       = (CMP_W'(pos_q) << 1) + CMP_W'(2);
  assign rc_ok      = rc_c < CMP_W'(cnt_q);
  assign sel_l      = lval_q < v_q;
  assign best_l_val = sel_l ? lval_q : v_q;
  assign sel_r      = rc_ok && (rdata_q < best_l_val);
  assign best_val   = sel_r ? rdata_q : lval_q;
  assign best_pos   = sel_r ? rc_c[IDX_W-1:0] : lc_c[IDX_W-1:0];
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    flags_o            = '0;
    flags_o.cmd        = cmd_q;
    flags_o.full       = cnt_q == CNT_W'(DEPTH);
    flags_o.empty      = cnt_q == '0;
    flags_o.idx_bad    = CMP_W'(idx_q) >= CMP_W'(cnt_q);
    flags_o.at_root    = pos_q == '0;
    flags_o.parent_gt  = rdata_q > v_q;
    flags_o.lc_ok      = lc_c < CMP_W'(cnt_q);
    flags_o.child_less = sel_l || sel_r;
    flags_o.cnt_one    = cnt_q == CNT_W'(1);
    flags_o.out_free   = out_free;
  end

  // Memory port selection.
  always_comb begin
    rd_en = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = pos_q;
    wdata = v_q;
    case (op_i)
      OP_SU_READ: begin
        rd_en = 1'b1;
        raddr = parent;
      end
      OP_SU_MOVE: begin
        we    = 1'b1;
        wdata = rdata_q;
      end
      OP_PLACE: begin
        we = 1'b1;
      end
      OP_RD_ROOT: begin
        rd_en = 1'b1;
      end
      OP_RD_LAST: begin
        rd_en = 1'b1;
        raddr = IDX_W'(cnt_q - CNT_W'(1));
      end
      OP_SD_READ_L: begin
        rd_en = 1'b1;
        raddr = lc_c[IDX_W-1:0];
      end
      OP_SD_READ_R: begin
        rd_en = 1'b1;
        raddr = rc_c[IDX_W-1:0];
      end
      OP_SD_MOVE: begin
        we    = 1'b1;
        wdata = best_val;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Count and result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (op_i)
        OP_INS_START: cnt_q <= cnt_q + CNT_W'(1);
        OP_EX_TAKE:   cnt_q <= cnt_q - CNT_W'(1);
        default:      cnt_q <= cnt_q;
      endcase
      if (op_i == OP_PUBLISH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        cmd_q        <= cmd_e'(cmd_i);
        key_q        <= key_value_i;
        idx_q        <= entry_index_i;
        res_value_q  <= '0;
        res_status_q <= STAT_OK;
      end
      OP_REFUSE: begin
        case (cmd_q)
          CMD_INSERT: res_status_q <= STAT_FULL;
          CMD_EXTRACT: begin
            res_status_q <= STAT_EMPTY;
            res_value_q  <= KEY_MAX;
          end
          default: res_status_q <= STAT_BAD_INDEX;
        endcase
      end
      OP_INS_START: begin
        v_q   <= key_q;
        pos_q <= IDX_W'(cnt_q);
      end
      OP_DEC_START: begin
        v_q   <= key_q;
        pos_q <= IDX_W'(idx_q);
      end
      OP_DEL_START: begin
        v_q   <= KEY_MIN;
        pos_q <= IDX_W'(idx_q);
      end
      OP_SU_MOVE: begin
        pos_q <= parent;
      end
      OP_RD_LAST: begin
        root_q <= rdata_q;
      end
      OP_EX_TAKE: begin
        v_q   <= rdata_q;
        pos_q <= '0;
        if (cmd_q == CMD_EXTRACT) begin
          res_value_q <= root_q;
        end
      end
      OP_SD_READ_R: begin
        lval_q <= rdata_q;
      end
      OP_SD_MOVE: begin
        pos_q <= best_pos;
      end
      OP_PUBLISH: begin
        out_value_q  <= res_value_q;
        out_status_q <= res_status_q;
        out_cnt_q    <= cnt_q;
      end
      default: begin
        pos_q <= pos_q;
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;
  assign entry_count_o  = ECNT_W'(out_cnt_q);

endmodule

`default_nettype wire

/* design/mhpq_ctrl.sv */
// Sequencer for the heap: walks each command through dispatch, sift up,
// root removal, sift down and result hand-off. Depends on mhpq_pkg.
`default_nettype none

module mhpq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mhpq_pkg::dp_status_t flags_i,
  output mhpq_pkg::dp_op_e     op_o
);
  import mhpq_pkg::*;

  ctrl_state_e state_q;
  ctrl_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_o       = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (flags_i.cmd)
          CMD_INSERT: begin
            if (flags_i.full) begin
              op_o    = OP_REFUSE;
              state_d = ST_FINISH;
            end else begin
              op_o    = OP_INS_START;
              state_d = ST_SU_REQ;
            end
          end
          CMD_EXTRACT: begin
            if (flags_i.empty) begin
              op_o    = OP_REFUSE;
              state_d = ST_FINISH;
            end else begin
              state_d = ST_EX_ROOT;
            end
          end
          CMD_DECREASE: begin
            if (flags_i.idx_bad) begin
              op_o    = OP_REFUSE;
              state_d = ST_FINISH;
            end else begin
              op_o    = OP_DEC_START;
              state_d = ST_SU_REQ;
            end
          end
          default: begin
            if (flags_i.idx_bad) begin
              op_o    = OP_REFUSE;
              state_d = ST_FINISH;
            end else begin
              op_o    = OP_DEL_START;
              state_d = ST_SU_REQ;
            end
          end
        endcase
      end
      ST_SU_REQ: begin
        if (flags_i.at_root) begin
          op_o    = OP_PLACE;
          state_d = (flags_i.cmd == CMD_DELETE) ? ST_EX_ROOT : ST_FINISH;
        end else begin
          op_o    = OP_SU_READ;
          state_d = ST_SU_CMP;
        end
      end
      ST_SU_CMP: begin
        if (flags_i.parent_gt) begin
          op_o    = OP_SU_MOVE;
          state_d = ST_SU_REQ;
        end else begin
          op_o    = OP_PLACE;
          state_d = (flags_i.cmd == CMD_DELETE) ? ST_EX_ROOT : ST_FINISH;
        end
      end
      ST_EX_ROOT: begin
        op_o    = OP_RD_ROOT;
        state_d = ST_EX_LAST;
      end
      ST_EX_LAST: begin
        op_o    = OP_RD_LAST;
        state_d = ST_EX_TAKE;
      end
      ST_EX_TAKE: begin
        op_o    = OP_EX_TAKE;
        state_d = flags_i.cnt_one ? ST_FINISH : ST_SD_LEFT;
      end
      ST_SD_LEFT: begin
        if (flags_i.lc_ok) begin
          op_o    = OP_SD_READ_L;
          state_d = ST_SD_RIGHT;
        end else begin
          op_o    = OP_PLACE;
          state_d = ST_FINISH;
        end
      end
      ST_SD_RIGHT: begin
        op_o    = OP_SD_READ_R;
        state_d = ST_SD_CMP;
      end
      ST_SD_CMP: begin
        if (flags_i.child_less) begin
          op_o    = OP_SD_MOVE;
          state_d = ST_SD_LEFT;
        end else begin
          op_o    = OP_PLACE;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (flags_i.out_free) begin
          op_o    = OP_PUBLISH;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/min_heap_priority_queue_core.sv */
// Top level of the binary min-heap priority queue: joins the sequencer
// and the datapath. Depends on mhpq_pkg, mhpq_if, mhpq_ctrl and mhpq_datapath.
//
//   Channel  Direction  Payload                                Transaction
//   cmd_i    in         cmd, key_value, entry_index            valid & ready
//   res_o    out        result_value, status, entry_count      valid & ready
//
// One command is worked on at a time, and the key memory serves one read or
// one write at a time. Each level climbed passes through ST_SU_REQ and
// ST_SU_CMP, each level descended through ST_SD_LEFT, ST_SD_RIGHT and ST_SD_CMP.
// Insert and decrease climb, extract removes the root and descends, delete
// climbs and then removes the root; a refused command goes straight to finish.
// Reset clears the key count, the result valid flag and the sequencer; the
// key memory is not cleared, as an entry at or above the count is never used.
// A finished result waits in the output register while the next command is
// taken in; only the hand-off of that next result stalls on res_o.ready.
`default_nettype none

module min_heap_priority_queue_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  mhpq_in_if.sink      cmd_i,
  mhpq_out_if.source   res_o
);
  import mhpq_pkg::*;

  dp_op_e     dp_op;
  dp_status_t dp_flags;
  logic       in_ready;

  mhpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (in_ready),
    .flags_i    (dp_flags),
    .op_o       (dp_op)
  );

  // The datapath holds the heap and drives the result channel directly.
  mhpq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (dp_op),
    .flags_o        (dp_flags),
    .cmd_i          (cmd_i.cmd),
    .key_value_i    (cmd_i.key_value),
    .entry_index_i  (cmd_i.entry_index),
    .out_ready_i    (res_o.ready),
    .out_valid_o    (res_o.valid),
    .result_value_o (res_o.result_value),
    .status_o       (res_o.status),
    .entry_count_o  (res_o.entry_count)
  );

  assign cmd_i.ready = in_ready;

endmodule

`default_nettype wire

/* design/mhpq_checker.sv */
// Port-level checks for the heap priority queue result channel, attached
// to the top level by bind. Depends on mhpq_pkg.
`default_nettype none

module mhpq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [mhpq_pkg::KEY_W-1:0] result_value_i,
  input logic [mhpq_pkg::STAT_W-1:0]       status_i,
  input logic [mhpq_pkg::ECNT_W-1:0]       entry_count_i
);
  import mhpq_pkg::*;

  // A result offered and not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> entry_count_i <= ECNT_W'(DEPTH))
    else $error("entry count beyond capacity");

  // An empty extract reports the largest key on an empty heap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STAT_EMPTY |->
      result_value_i == KEY_MAX && entry_count_i == '0)
    else $error("empty status with wrong value or count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STAT_FULL |-> entry_count_i == ECNT_W'(DEPTH))
    else $error("full status while not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == STAT_FULL || status_i == STAT_BAD_INDEX) |->
      result_value_i == '0)
    else $error("refused command returned a non-zero value");

endmodule

bind min_heap_priority_queue_core mhpq_checker u_mhpq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .result_value_i (res_o.result_value),
  .status_i       (res_o.status),
  .entry_count_i  (res_o.entry_count)
);

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for min_heap_priority_queue_core: a mirror heap predicts each
// result, and randomised traffic runs under several idling patterns on both channels.
// Depends on mhpq_pkg, the mhpq_in_if/mhpq_out_if interfaces and the heap RTL.
`timescale 1ns / 100ps

module testbench;
  import mhpq_pkg::*;

  // Longest stretch without any transaction before the run is declared hung.
  // The slowest command is a delete that climbs and then descends through all ten
  // levels; the limit leaves a wide margin over it and over the longest random gap
  // on either side.
  localparam int unsigned QUIET_LIMIT  = 2000;
  // Cycles allowed after the last expected result, for any stray result to show.
  localparam int unsigned DRAIN_CYCLES = 100;

  // One result transaction as the heap should present it.
  typedef struct packed {
    logic signed [KEY_W-1:0] result_value;
    logic [STAT_W-1:0]       status;
    logic [ECNT_W-1:0]       entry_count;
  } heap_result_t;

  // Mirror of the heap: its own copy of the key array and the count, and the
  // queue of results that the design still owes.
  class min_heap_mirror;
    logic signed [KEY_W-1:0] keys [DEPTH];
    int unsigned             held;
    heap_result_t            awaited [$];
    int unsigned             mismatches;

    function new();
      held       = 0;
      mismatches = 0;
      foreach (keys[i]) keys[i] = '0;
    endfunction

    function void swap_keys(int unsigned a, int unsigned b);
      logic signed [KEY_W-1:0] t;
      t       = keys[a];
      keys[a] = keys[b];
      keys[b] = t;
    endfunction

    // Moves the key at pos towards the root while its parent is larger.
    function void climb(int unsigned pos);
      int unsigned up;
      while (pos != 0) begin
        up = (pos - 1) / 2;
        if (keys[up] <= keys[pos]) break;
        swap_keys(pos, up);
        pos = up;
      end
    endfunction

    // Moves the key at pos towards the leaves while a child is smaller.
    function void sink(int unsigned pos);
      int unsigned lc;
      int unsigned rc;
      int unsigned best;
      bit          settled;
      settled = 1'b0;
      while (!settled) begin
        lc   = 2 * pos + 1;
        rc   = 2 * pos + 2;
        best = pos;
        if (lc < held && keys[lc] < keys[best]) best = lc;
        if (rc < held && keys[rc] < keys[best]) best = rc;
        if (best == pos) begin
          settled = 1'b1;
        end else begin
          swap_keys(pos, best);
          pos = best;
        end
      end
    endfunction

    function logic signed [KEY_W-1:0] take_root();
      logic signed [KEY_W-1:0] top;
      top  = keys[0];
      held = held - 1;
      if (held > 0) begin
        keys[0] = keys[held];
        sink(0);
      end
      return top;
    endfunction

    // Applies one accepted command and queues the result it must produce.
    function void note_command(cmd_e op, logic signed [KEY_W-1:0] key,
                               logic [EIDX_W-1:0] idx);
      heap_result_t r;
      r.result_value = '0;
      r.status       = STAT_OK;
      case (op)
        CMD_INSERT: begin
          if (held >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            keys[held] = key;
            held       = held + 1;
            climb(held - 1);
          end
        end
        CMD_EXTRACT: begin
          if (held == 0) begin
            r.status       = STAT_EMPTY;
            r.result_value = KEY_MAX;
          end else begin
            r.result_value = take_root();
          end
        end
        CMD_DECREASE: begin
          if (idx >= held) begin
            r.status = STAT_BAD_INDEX;
          end else begin
            keys[idx] = key;
            climb(idx);
          end
        end
        default: begin
          if (idx >= held) begin
            r.status = STAT_BAD_INDEX;
          end else begin
            keys[idx] = KEY_MIN;
            climb(idx);
            void'(take_root());
          end
        end
      endcase
      r.entry_count = held[ECNT_W-1:0];
      awaited.push_back(r);
    endfunction

    // Compares one accepted result with the oldest one still awaited.
    function void check_result(logic signed [KEY_W-1:0] value, logic [STAT_W-1:0] code,
                               logic [ECNT_W-1:0] cnt);
      heap_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result: value %0d status %0d count %0d",
                 $time, value, code, cnt);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (value !== want.result_value) begin
        $display("%0t: result_value expected %0d, actual %0d",
                 $time, want.result_value, value);
        mismatches++;
      end
      if (code !== want.status) begin
        $display("%0t: status expected %0d, actual %0d", $time, want.status, code);
        mismatches++;
      end
      if (cnt !== want.entry_count) begin
        $display("%0t: entry_count expected %0d, actual %0d",
                 $time, want.entry_count, cnt);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mhpq_in_if  cmd_if ();
  mhpq_out_if res_if ();

  min_heap_priority_queue_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  min_heap_mirror mirror;

  // Percentages of cycles in which the command side holds back and the result
  // side refuses a transaction; the test phases set them as they go.
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result side: a result is checked at the edge at which it is accepted, and
  // ready for the next cycle is drawn afresh, so stalls fall on every phase of
  // the heap's work. Values read here are those from just before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      mirror.check_result(res_if.result_value, res_if.status, res_if.entry_count);
    res_if.ready <= rst_ni && ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: any transaction on either channel resets the count of quiet cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("min_heap_priority_queue_core verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Keys are mostly uniform over the whole range; some come from a narrow band
  // around zero so that duplicates are common, and some are the extremes, their neighbours, zero or minus one.
  function automatic logic signed [KEY_W-1:0] draw_key();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return $urandom;
    if (pick < 85) return $signed($urandom_range(40)) - 20;
    case ($urandom_range(5))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2:       return KEY_MIN + 1;
      3:       return KEY_MAX - 1;
      4:       return '0;
      default: return '1;
    endcase
  endfunction

  // Offers one command and returns at the edge at which it is accepted. The
  // valid line is left high afterwards; it drops only when the next call
  // decides to idle or the test ends, so it is never lowered and raised within one time step.
  task automatic issue_command(input cmd_e op, input logic signed [KEY_W-1:0] key,
                               input logic [EIDX_W-1:0] idx);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      cmd_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.cmd         <= op;
    cmd_if.key_value   <= key;
    cmd_if.entry_index <= idx;
    do @(posedge clk_i); while (!cmd_if.ready);
    mirror.note_command(op, key, idx);
  endtask

  // One random command. insert_pct steers the heap towards growth or shrinkage;
  // the other three operations share the rest equally. Decrease and delete
  // usually name a live entry, and a bad index (at or above the count) in
  // bad_pct of cases, or always when the heap is empty, and never when it is full.
  task automatic random_command(input int unsigned insert_pct, input int unsigned bad_pct);
    cmd_e              op;
    logic [EIDX_W-1:0] idx;
    int unsigned       pick;
    if ($urandom_range(99) < insert_pct) begin
      op = CMD_INSERT;
    end else begin
      pick = $urandom_range(2);
      case (pick)
        0:       op = CMD_EXTRACT;
        1:       op = CMD_DECREASE;
        default: op = CMD_DELETE;
      endcase
    end
    if (mirror.held < DEPTH && (mirror.held == 0 || $urandom_range(99) < bad_pct))
      idx = EIDX_W'($urandom_range(DEPTH - 1, mirror.held));
    else
      idx = EIDX_W'($urandom_range(mirror.held - 1, 0));
    issue_command(op, draw_key(), idx);
  endtask

  initial begin
    mirror                = new();
    cmd_if.valid          = 1'b0;
    cmd_if.cmd            = CMD_INSERT;
    cmd_if.key_value      = '0;
    cmd_if.entry_index    = '0;
    res_if.ready          = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, without idling. The first three commands meet an empty heap:
    // an extract must report empty with the largest key, and both indexed
    // commands must report a bad index.
    issue_command(CMD_EXTRACT,  '0, '0);
    issue_command(CMD_DECREASE, '0, '0);
    issue_command(CMD_DELETE,   '0, '1);
    // The extreme keys, a few neighbours of zero and a duplicate.
    issue_command(CMD_INSERT, KEY_MAX, '0);
    issue_command(CMD_INSERT, KEY_MIN, '0);
    issue_command(CMD_INSERT, '0,      '0);
    issue_command(CMD_INSERT, '1,      '0);
    issue_command(CMD_INSERT, 32'sd1,  '0);
    issue_command(CMD_INSERT, KEY_MAX, '0);
    // A decrease of the last leaf to the minimum climbs until it meets the equal key at the root; a
    // "decrease" to a larger value is written in place and never sinks, which
    // leaves the order below it broken on purpose.
    issue_command(CMD_DECREASE, KEY_MIN, 10'd5);
    issue_command(CMD_DECREASE, KEY_MAX, 10'd2);
    // Delete at the root and at the last position, then an index equal to the count.
    issue_command(CMD_DELETE, '0, '0);
    issue_command(CMD_DELETE, '0, EIDX_W'(mirror.held - 1));
    issue_command(CMD_DECREASE, 32'sd7, EIDX_W'(mirror.held));
    issue_command(CMD_EXTRACT, '0, '0);
    // Alternating bit patterns on every payload bit.
    issue_command(CMD_INSERT, 32'sh5555_5555, '1);
    issue_command(CMD_INSERT, 32'shAAAA_AAAA, 10'h155);
    issue_command(CMD_DECREASE, 32'sh5555_5555, '1);
    issue_command(CMD_DELETE,   32'shAAAA_AAAA, 10'h155);
    // Drain to empty and ask once more.
    while (mirror.held != 0) issue_command(CMD_EXTRACT, '0, '0);
    issue_command(CMD_EXTRACT, '0, '0);

    // Random part. First a small heap at full speed on both sides.
    repeat (150) random_command(55, 10);

    // Sender mostly idle; inserts about balance extracts and deletes.
    src_idle_pct = 70;
    repeat (150) random_command(40, 15);

    // Receiver mostly stalling while the heap is filled to the brim, so that
    // sifts walk all ten levels. Once full, inserts must be refused and every
    // index is live.
    src_idle_pct   = 0;
    sink_stall_pct = 70;
    while (mirror.held < DEPTH) random_command(90, 5);
    repeat (16) random_command(50, 5);

    // Light idling on both sides while the heap is drained again.
    src_idle_pct   = 15;
    sink_stall_pct = 15;
    repeat (200) random_command(20, 10);

    cmd_if.valid <= 1'b0;

    // Wait for every awaited result, then a little longer for any stray one.
    while (mirror.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mirror.mismatches == 0)
      $display("min_heap_priority_queue_core verification clean");
    else
      $display("min_heap_priority_queue_core verification failed");
    $finish;
  end

endmodule
